// ----- sv/stt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes of the software timer table unit.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_REG     = 3'd1;
  localparam logic [2:0] ACT_DEL     = 3'd2;
  localparam logic [2:0] ACT_EN      = 3'd3;
  localparam logic [2:0] ACT_DIS     = 3'd4;
  localparam logic [2:0] ACT_SERVICE = 3'd5;

  localparam int MAX_RESULTS = 8;
  localparam int NFW         = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  slot_index;
    logic [31:0] period_ms;
    logic        loop_mode;
    logic        has_handler;
  } stt_in_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] result_index;
    logic       fired;
    logic       last;
  } stt_out_t;

  typedef enum logic [1:0] {
    CNT_DEC,
    CNT_RELOAD,
    CNT_ZERO,
    CNT_PERIOD
  } cnt_src_t;

  typedef struct packed {
    logic     wr_count;
    logic     wr_reload;
    cnt_src_t src;
  } cu_ctl_t;

endpackage
`default_nettype wire

// ----- sv/stt_count_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_count_unit
// Reload and countdown memories; shared decrement, reload, clear, load path.
// ----------------------------------------------------------------------------
module stt_count_unit
  import stt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  wire logic                                  clk,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  wire cu_ctl_t                               ctl,
  input  wire logic [31:0]                           period_i,
  output logic                                       count_zero_o
);

  logic [31:0] reload_mem [SLOTS];
  logic [31:0] count_mem  [SLOTS];
  logic [31:0] rd_reload_q;
  logic [31:0] rd_count_q;
  logic [31:0] count_wdata;

  always_comb begin
    case (ctl.src)
      CNT_DEC:    count_wdata = rd_count_q - 32'd1;
      CNT_RELOAD: count_wdata = rd_reload_q;
      CNT_ZERO:   count_wdata = '0;
      default:    count_wdata = period_i;
    endcase
  end

  assign count_zero_o = (rd_count_q == '0);

  always_ff @(posedge clk) begin
    if (ctl.wr_count) begin
      count_mem[wr_addr] <= count_wdata;
    end
    if (ctl.wr_reload) begin
      reload_mem[wr_addr] <= period_i;
    end
    rd_reload_q <= reload_mem[rd_addr];
    rd_count_q  <= count_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- sv/software_timer_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table_unit
// Timer slot table driven by tick, register, delete, enable, disable and
// service commands; a small sequencer visits one slot per unstalled cycle.
// ----------------------------------------------------------------------------
// One command is taken at a time. A tick sweeps all slots through the shared
// countdown unit, one slot a cycle with a registered memory read ahead of the
// update; a final step sends the result. Register scans the flags for the
// first free slot; service scans slots up to the eighth fired one, holding
// while the result side stalls, and sends one beat per fired slot, at most
// eight. Delete, enable and disable pass the single-slot and final states. No
// clearing pass is needed after reset: a per-slot flag marks a loaded reload
// value, and entries without it are never used.
// ----------------------------------------------------------------------------
module software_timer_table_unit
  import stt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire stt_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output stt_out_t      out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_SINGLE,
    S_FIN
  } state_t;

  localparam stt_out_t RES_NONE = '{ok: 1'b0, result_index: 3'd0, fired: 1'b0, last: 1'b1};

  state_t          state_r, state_nxt;
  logic [2:0]      act_r, act_nxt;
  logic [IW-1:0]   sel_r, sel_nxt;
  logic            in_range_r, in_range_nxt;
  logic [31:0]     period_r, period_nxt;
  logic            loop_r, loop_nxt;
  logic            hnd_r, hnd_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            ex_v_r, ex_v_nxt;
  logic [IW-1:0]   ex_idx_r, ex_idx_nxt;
  logic            held_v_r, held_v_nxt;
  logic [IW-1:0]   held_idx_r, held_idx_nxt;
  logic [NFW-1:0]  nfound_r, nfound_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] periodic_r, periodic_nxt;
  logic [SLOTS-1:0] pending_r, pending_nxt;
  logic [SLOTS-1:0] handled_r, handled_nxt;
  logic [SLOTS-1:0] nz_r, nz_nxt;
  stt_out_t        fin_r, fin_nxt;
  logic            out_valid_r, out_valid_nxt;
  stt_out_t        out_r, out_nxt;

  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  cu_ctl_t         cu_ctl;
  logic            count_zero;
  logic [IW-1:0]   cur;
  logic [IW-1:0]   in_sel;
  logic [IW+2:0]   in_sel_ext;
  logic            last_slot;
  logic            out_free;
  logic            elig;
  logic            ok;

  function automatic logic [2:0] ridx(input logic [IW-1:0] i);
    logic [IW+2:0] e;
    e = (IW + 3)'(i);
    return e[2:0];
  endfunction

  stt_count_unit #(
    .SLOTS (SLOTS)
  ) u_cu (
    .clk          (clk),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .ctl          (cu_ctl),
    .period_i     (period_r),
    .count_zero_o (count_zero)
  );

  assign cur        = idx_r[IW-1:0];
  assign in_sel_ext = (IW + 3)'(in_data.slot_index);
  assign in_sel     = in_sel_ext[IW-1:0];
  assign last_slot  = (idx_r == CW'(SLOTS - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign elig       = active_r[cur] && handled_r[cur] && pending_r[cur];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    sel_nxt       = sel_r;
    in_range_nxt  = in_range_r;
    period_nxt    = period_r;
    loop_nxt      = loop_r;
    hnd_nxt       = hnd_r;
    idx_nxt       = idx_r;
    ex_v_nxt      = ex_v_r;
    ex_idx_nxt    = ex_idx_r;
    held_v_nxt    = held_v_r;
    held_idx_nxt  = held_idx_r;
    nfound_nxt    = nfound_r;
    active_nxt    = active_r;
    periodic_nxt  = periodic_r;
    pending_nxt   = pending_r;
    handled_nxt   = handled_r;
    nz_nxt        = nz_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    cu_ctl        = '{wr_count: 1'b0, wr_reload: 1'b0, src: CNT_DEC};
    rd_addr       = cur;
    wr_addr       = ex_idx_r;
    ok            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // read ahead at the requested slot so enable has the reload next cycle
        rd_addr = in_sel;
        if (in_valid) begin
          act_nxt      = in_data.action;
          sel_nxt      = in_sel;
          in_range_nxt = ({29'b0, in_data.slot_index} < 32'(SLOTS));
          period_nxt   = in_data.period_ms;
          loop_nxt     = in_data.loop_mode;
          hnd_nxt      = in_data.has_handler;
          idx_nxt      = '0;
          ex_v_nxt     = 1'b0;
          held_v_nxt   = 1'b0;
          nfound_nxt   = '0;
          fin_nxt      = RES_NONE;
          case (in_data.action) inside
            ACT_TICK, ACT_SERVICE: state_nxt = S_SWEEP;
            ACT_REG: state_nxt = (in_data.period_ms != '0) ? S_SWEEP : S_FIN;
            ACT_DEL, ACT_EN, ACT_DIS: state_nxt = S_SINGLE;
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_SWEEP: begin
        case (act_r)
          ACT_TICK: begin
            // update stage works on the slot read in the previous cycle
            if (ex_v_r && active_r[ex_idx_r] && nz_r[ex_idx_r]) begin
              if (!count_zero) begin
                cu_ctl.wr_count = 1'b1;
                cu_ctl.src      = CNT_DEC;
              end else begin
                pending_nxt[ex_idx_r] = 1'b1;
                if (periodic_r[ex_idx_r]) begin
                  cu_ctl.wr_count = 1'b1;
                  cu_ctl.src      = CNT_RELOAD;
                end
              end
            end
            if (idx_r == CW'(SLOTS)) begin
              ex_v_nxt  = 1'b0;
              fin_nxt   = RES_NONE;
              state_nxt = S_FIN;
            end else begin
              ex_v_nxt   = 1'b1;
              ex_idx_nxt = cur;
              idx_nxt    = idx_r + CW'(1);
            end
          end

          ACT_REG: begin
            wr_addr = cur;
            if (!active_r[cur] && !nz_r[cur]) begin
              cu_ctl            = '{wr_count: 1'b1, wr_reload: 1'b1, src: CNT_PERIOD};
              active_nxt[cur]   = 1'b1;
              periodic_nxt[cur] = loop_r;
              pending_nxt[cur]  = 1'b0;
              handled_nxt[cur]  = hnd_r;
              nz_nxt[cur]       = 1'b1;
              fin_nxt           = '{ok: 1'b1, result_index: ridx(cur), fired: 1'b0,
                                    last: 1'b1};
              state_nxt         = S_FIN;
            end else if (last_slot) begin
              fin_nxt   = RES_NONE;
              state_nxt = S_FIN;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end

          default: begin
            // service: hold the newest fired slot until we know if it is last
            if (!(elig && held_v_r && !out_free)) begin
              if (elig) begin
                pending_nxt[cur] = 1'b0;
                if (!periodic_r[cur]) begin
                  active_nxt[cur] = 1'b0;
                end
                if (held_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = '{ok: 1'b0, result_index: ridx(held_idx_r), fired: 1'b1,
                                    last: 1'b0};
                end
                held_v_nxt   = 1'b1;
                held_idx_nxt = cur;
                nfound_nxt   = nfound_r + NFW'(1);
              end
              if ((elig && nfound_r == NFW'(MAX_RESULTS - 1)) || last_slot) begin
                if (elig || held_v_r) begin
                  fin_nxt = '{ok: 1'b0, result_index: ridx(elig ? cur : held_idx_r),
                              fired: 1'b1, last: 1'b1};
                end else begin
                  fin_nxt = RES_NONE;
                end
                state_nxt = S_FIN;
              end else begin
                idx_nxt = idx_r + CW'(1);
              end
            end
          end
        endcase
      end

      S_SINGLE: begin
        wr_addr = sel_r;
        case (act_r)
          ACT_DEL: begin
            ok = in_range_r && active_r[sel_r] && nz_r[sel_r];
            if (ok) begin
              active_nxt[sel_r]   = 1'b0;
              periodic_nxt[sel_r] = 1'b0;
              pending_nxt[sel_r]  = 1'b0;
              handled_nxt[sel_r]  = 1'b0;
              nz_nxt[sel_r]       = 1'b0;
            end
          end
          ACT_EN: begin
            ok = in_range_r && nz_r[sel_r];
            if (ok) begin
              cu_ctl.wr_count    = 1'b1;
              cu_ctl.src         = CNT_RELOAD;
              pending_nxt[sel_r] = 1'b0;
              active_nxt[sel_r]  = 1'b1;
            end
          end
          default: begin
            ok = in_range_r && nz_r[sel_r];
            if (ok) begin
              cu_ctl.wr_count    = 1'b1;
              cu_ctl.src         = CNT_ZERO;
              pending_nxt[sel_r] = 1'b0;
              active_nxt[sel_r]  = 1'b0;
            end
          end
        endcase
        fin_nxt   = '{ok: ok, result_index: 3'd0, fired: 1'b0, last: 1'b1};
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = fin_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      ex_v_r      <= 1'b0;
      held_v_r    <= 1'b0;
      nfound_r    <= '0;
      active_r    <= '0;
      periodic_r  <= '0;
      pending_r   <= '0;
      handled_r   <= '0;
      nz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ex_v_r      <= ex_v_nxt;
      held_v_r    <= held_v_nxt;
      nfound_r    <= nfound_nxt;
      active_r    <= active_nxt;
      periodic_r  <= periodic_nxt;
      pending_r   <= pending_nxt;
      handled_r   <= handled_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    sel_r      <= sel_nxt;
    in_range_r <= in_range_nxt;
    period_r   <= period_nxt;
    loop_r     <= loop_nxt;
    hnd_r      <= hnd_nxt;
    ex_idx_r   <= ex_idx_nxt;
    held_idx_r <= held_idx_nxt;
    fin_r      <= fin_nxt;
    out_r      <= out_nxt;
  end

  // an accepted command always leaves the block busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after accepting a command");

  // only slots with a loaded reload value can be active or pending
  assert property (@(posedge clk) disable iff (!rst_n)
    ((active_r & ~nz_r) == '0) && ((pending_r & ~nz_r) == '0))
    else $error("active or pending slot without reload value");

  // service never reports more than the beat limit
  assert property (@(posedge clk) disable iff (!rst_n)
    nfound_r <= NFW'(MAX_RESULTS))
    else $error("service found count past limit");

  // result beats are only produced by the sweep or the final step
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_FIN
      || $past(state_r) == S_SWEEP))
    else $error("result beat raised outside sweep or final step");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the software timer table unit. Commands go in over
// the valid/stall input channel while a behavioral copy of the slot table
// predicts every result beat. Directed sequences cover the empty and full
// table, expiry and a service at the beat limit. A receiver hold-off fills
// the block, and a long stretch of random commands follows, with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module tb_top
  import stt_pkg::*;
();

  localparam int         NUM_SLOTS  = 8;
  localparam int         SETTLE     = 2 * NUM_SLOTS + 8;
  localparam logic [2:0] ACT_BAD_A  = 3'd6;
  localparam logic [2:0] ACT_BAD_B  = 3'd7;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  stt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stt_out_t out_data;

  // pacing knobs for the sender and the result side
  bit idle_on     = 1'b1;
  bit stall_on    = 1'b1;
  int hold_cycles = 0;
  int mismatches  = 0;

  // predicted slot table
  bit          slot_active   [NUM_SLOTS];
  bit          slot_periodic [NUM_SLOTS];
  bit          slot_pending  [NUM_SLOTS];
  bit          slot_handled  [NUM_SLOTS];
  logic [31:0] slot_reload   [NUM_SLOTS];
  logic [31:0] slot_count    [NUM_SLOTS];

  stt_out_t expected_beats[$];

  software_timer_table_unit #(.SLOTS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 2);
    if (r < 18) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_beat(input bit ok, input int idx, input bit fired,
                                    input bit last);
    stt_out_t b;
    b.ok           = ok;
    b.result_index = idx[2:0];
    b.fired        = fired;
    b.last         = last;
    expected_beats.push_back(b);
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_active[i]   = 1'b0;
      slot_periodic[i] = 1'b0;
      slot_pending[i]  = 1'b0;
      slot_handled[i]  = 1'b0;
      slot_reload[i]   = '0;
      slot_count[i]    = '0;
    end
  endfunction

  // applies one accepted command to the table and queues its beats
  function automatic void model_command(input stt_in_t c);
    int s;
    int hits[$];
    bit done;
    s    = c.slot_index;
    done = 1'b0;
    case (c.action)
      ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_active[i] && slot_reload[i] != 0) begin
            if (slot_count[i] != 0) begin
              slot_count[i] = slot_count[i] - 1;
            end else begin
              slot_pending[i] = 1'b1;
              if (slot_periodic[i]) slot_count[i] = slot_reload[i];
            end
          end
        end
        push_beat(0, 0, 0, 1);
      end
      ACT_REG: begin
        if (c.period_ms != 0) begin
          for (int i = 0; i < NUM_SLOTS && !done; i++) begin
            if (!slot_active[i] && slot_reload[i] == 0) begin
              slot_periodic[i] = c.loop_mode;
              slot_pending[i]  = 1'b0;
              slot_reload[i]   = c.period_ms;
              slot_count[i]    = c.period_ms;
              slot_handled[i]  = c.has_handler;
              slot_active[i]   = 1'b1;
              push_beat(1, i, 0, 1);
              done = 1'b1;
            end
          end
        end
        if (!done) push_beat(0, 0, 0, 1);
      end
      ACT_DEL: begin
        if (slot_active[s] && slot_reload[s] != 0) begin
          slot_active[s]   = 1'b0;
          slot_periodic[s] = 1'b0;
          slot_pending[s]  = 1'b0;
          slot_handled[s]  = 1'b0;
          slot_reload[s]   = '0;
          slot_count[s]    = '0;
          push_beat(1, 0, 0, 1);
        end else begin
          push_beat(0, 0, 0, 1);
        end
      end
      ACT_EN: begin
        if (slot_reload[s] != 0) begin
          slot_count[s]   = slot_reload[s];
          slot_pending[s] = 1'b0;
          slot_active[s]  = 1'b1;
          push_beat(1, 0, 0, 1);
        end else begin
          push_beat(0, 0, 0, 1);
        end
      end
      ACT_DIS: begin
        if (slot_reload[s] != 0) begin
          slot_active[s]  = 1'b0;
          slot_pending[s] = 1'b0;
          slot_count[s]   = '0;
          push_beat(1, 0, 0, 1);
        end else begin
          push_beat(0, 0, 0, 1);
        end
      end
      ACT_SERVICE: begin
        for (int i = 0; i < NUM_SLOTS && hits.size() < MAX_RESULTS; i++) begin
          if (slot_active[i] && slot_handled[i] && slot_pending[i]) begin
            slot_pending[i] = 1'b0;
            if (!slot_periodic[i]) slot_active[i] = 1'b0;
            hits.push_back(i);
          end
        end
        if (hits.size() == 0) push_beat(0, 0, 0, 1);
        foreach (hits[k]) push_beat(0, hits[k], 1, k == hits.size() - 1);
      end
      default: push_beat(0, 0, 0, 1);
    endcase
  endfunction

  // offers one command and returns at the edge where it is taken;
  // valid stays high so a back-to-back command follows without a bubble
  task automatic send_cmd(input logic [2:0] act, input logic [2:0] sel,
                          input logic [31:0] per, input logic lp, input logic hd);
    stt_in_t c;
    int gap;
    c.action      = act;
    c.slot_index  = sel;
    c.period_ms   = per;
    c.loop_mode   = lp;
    c.has_handler = hd;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_command(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result side: random stalls, or one long hold when a test asks for it
  initial begin : result_pacing
    int run;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        run = 1 + gap_len();
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    stt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("ok", want.ok, out_data.ok);
        check_field("result_index", want.result_index, out_data.result_index);
        check_field("fired", want.fired, out_data.fired);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // every command against an empty table is a no-op
  task automatic test_empty_table();
    send_cmd(ACT_SERVICE, 3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_TICK,    3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_DEL,     3'd7, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_EN,      3'd0, 32'd9, 1'b1, 1'b1);
    send_cmd(ACT_DIS,     3'd3, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_REG,     3'd0, 32'd0, 1'b1, 1'b1);
    send_cmd(ACT_BAD_A,   3'd5, 32'hA5A5_5A5A, 1'b1, 1'b0);
    send_cmd(ACT_BAD_B,   3'd2, 32'h5A5A_A5A5, 1'b0, 1'b1);
    drain();
  endtask

  // max period, delete, then fill every slot and overflow the table
  task automatic test_full_table();
    send_cmd(ACT_REG, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_cmd(ACT_DEL, 3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_REG, 3'd0, 32'd1, 1'b0, 1'b1);
    for (int i = 1; i < NUM_SLOTS; i++) send_cmd(ACT_REG, 3'd0, 32'd1, 1'b1, 1'b1);
    send_cmd(ACT_REG, 3'd0, 32'd5, 1'b1, 1'b1);
    drain();
  endtask

  // all slots expire together, service reports eight beats, then the
  // retired one-shot slot is revived and deleted
  task automatic test_expiry_service();
    send_cmd(ACT_TICK,    3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_TICK,    3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_SERVICE, 3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_EN,      3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_DEL,     3'd0, 32'd0, 1'b0, 1'b0);
    send_cmd(ACT_DIS,     3'd7, 32'd0, 1'b0, 1'b0);
    drain();
  endtask

  // receiver holds off while commands keep coming, so the block backs up
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = 250;
    for (int k = 0; k < 24; k++) begin
      case (k % 3)
        0:       send_cmd(ACT_TICK, 3'd0, 32'd0, 1'b0, 1'b0);
        1:       send_cmd(ACT_REG, 3'($urandom), $urandom_range(1, 3), 1'($urandom), 1'b1);
        default: send_cmd(ACT_SERVICE, 3'd0, 32'd0, 1'b0, 1'b0);
      endcase
    end
    drain();
    idle_on = 1'b1;
  endtask

  task automatic send_random();
    logic [2:0]  act;
    logic [31:0] per;
    int r;
    r = $urandom_range(0, 99);
    if (r < 32)      act = ACT_TICK;
    else if (r < 52) act = ACT_REG;
    else if (r < 70) act = ACT_SERVICE;
    else if (r < 79) act = ACT_DEL;
    else if (r < 87) act = ACT_EN;
    else if (r < 96) act = ACT_DIS;
    else             act = r[0] ? ACT_BAD_A : ACT_BAD_B;
    // short periods so slots expire often, a few zero or full-width ones
    r = $urandom_range(0, 19);
    if (r < 12)      per = $urandom_range(1, 4);
    else if (r < 15) per = $urandom_range(5, 12);
    else if (r < 17) per = '0;
    else             per = $urandom();
    send_cmd(act, 3'($urandom), per, 1'($urandom), $urandom_range(0, 3) != 0);
  endtask

  task automatic test_random_traffic(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        idle_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      send_random();
    end
    drain();
  endtask

  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_full_table();
    test_expiry_service();
    test_backpressure();
    test_random_traffic(280);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/stt_pkg.sv
sv/stt_count_unit.sv
sv/software_timer_table_unit.sv
sim/tb_top.sv
